FILE: rtl/u16550rf_pkg.sv
// shared types and constants for the 16550-style uart register file
package u16550rf_pkg;

	localparam int OP_W   = 2;
	localparam int OFF_W  = 3;
	localparam int BYTE_W = 8;

	localparam int S_TDATA_W = 24;
	localparam int S_TUSER_W = OP_W;
	localparam int M_TDATA_W = 16;
	localparam int M_TUSER_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_RX    = 2'd2
	} op_t;

	localparam logic [OFF_W-1:0] OFF_RBR_THR = 3'd0;
	localparam logic [OFF_W-1:0] OFF_IER     = 3'd1;
	localparam logic [OFF_W-1:0] OFF_IIR_FCR = 3'd2;
	localparam logic [OFF_W-1:0] OFF_LCR     = 3'd3;
	localparam logic [OFF_W-1:0] OFF_MCR     = 3'd4;
	localparam logic [OFF_W-1:0] OFF_LSR     = 3'd5;
	localparam logic [OFF_W-1:0] OFF_MSR     = 3'd6;
	localparam logic [OFF_W-1:0] OFF_SCR     = 3'd7;

	localparam int DLAB_BIT = 7;

	localparam logic [BYTE_W-1:0] IIR_NONE  = 8'h01;
	localparam logic [BYTE_W-1:0] LSR_DR    = 8'h01;
	localparam logic [BYTE_W-1:0] LSR_THRE  = 8'h20;
	localparam logic [BYTE_W-1:0] LSR_TEMT  = 8'h40;
	localparam logic [BYTE_W-1:0] DLL_RESET = 8'h01;

	typedef struct packed {
		op_t               op;
		logic [OFF_W-1:0]  offset;
		logic [BYTE_W-1:0] write_data;
		logic [BYTE_W-1:0] rx_data;
	} item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] read_data;
		logic              tx_valid;
		logic [BYTE_W-1:0] tx_byte;
		logic              rx_dropped;
	} result_t;

endpackage

FILE: rtl/u16550rf_regs.sv
// uart register state, access decode and result logic
module u16550rf_regs (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  u16550rf_pkg::item_t    item,
	output u16550rf_pkg::result_t  result
);

	logic [u16550rf_pkg::BYTE_W-1:0] ier_q;
	logic [u16550rf_pkg::BYTE_W-1:0] lcr_q;
	logic [u16550rf_pkg::BYTE_W-1:0] mcr_q;
	logic [u16550rf_pkg::BYTE_W-1:0] scr_q;
	logic [u16550rf_pkg::BYTE_W-1:0] dll_q;
	logic [u16550rf_pkg::BYTE_W-1:0] dlm_q;
	logic                            rx_full_q;
	logic [u16550rf_pkg::BYTE_W-1:0] rx_hold_q;
	logic                            dlab;
	logic                            rbr_read;

	assign dlab = lcr_q[u16550rf_pkg::DLAB_BIT];
	assign rbr_read = (item.op == u16550rf_pkg::OP_READ)
		&& (item.offset == u16550rf_pkg::OFF_RBR_THR) && !dlab;

	always_comb begin
		result = '0;
		case (item.op)
			u16550rf_pkg::OP_READ: begin
				unique case (item.offset)
					u16550rf_pkg::OFF_RBR_THR: result.read_data = dlab ? dll_q :
						(rx_full_q ? rx_hold_q : '0);
					u16550rf_pkg::OFF_IER:     result.read_data = dlab ? dlm_q : ier_q;
					u16550rf_pkg::OFF_IIR_FCR: result.read_data = u16550rf_pkg::IIR_NONE;
					u16550rf_pkg::OFF_LCR:     result.read_data = lcr_q;
					u16550rf_pkg::OFF_MCR:     result.read_data = mcr_q;
					u16550rf_pkg::OFF_LSR:     result.read_data = u16550rf_pkg::LSR_THRE
						| u16550rf_pkg::LSR_TEMT | (rx_full_q ? u16550rf_pkg::LSR_DR : '0);
					u16550rf_pkg::OFF_MSR:     result.read_data = '0;
					u16550rf_pkg::OFF_SCR:     result.read_data = scr_q;
					default:                   result.read_data = '0;
				endcase
			end
			u16550rf_pkg::OP_WRITE: begin
				if (item.offset == u16550rf_pkg::OFF_RBR_THR && !dlab) begin
					result.tx_valid = 1'b1;
					result.tx_byte  = item.write_data;
				end
			end
			u16550rf_pkg::OP_RX: begin
				result.rx_dropped = rx_full_q;
			end
			default: result = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ier_q     <= '0;
			lcr_q     <= '0;
			mcr_q     <= '0;
			scr_q     <= '0;
			dll_q     <= u16550rf_pkg::DLL_RESET;
			dlm_q     <= '0;
			rx_full_q <= 1'b0;
			rx_hold_q <= '0;
		end else if (fire) begin
			if (rbr_read) begin
				rx_full_q <= 1'b0;
			end
			if (item.op == u16550rf_pkg::OP_RX && !rx_full_q) begin
				rx_hold_q <= item.rx_data;
				rx_full_q <= 1'b1;
			end
			if (item.op == u16550rf_pkg::OP_WRITE) begin
				unique case (item.offset)
					u16550rf_pkg::OFF_RBR_THR: begin
						if (dlab) dll_q <= item.write_data;
					end
					u16550rf_pkg::OFF_IER: begin
						if (dlab) dlm_q <= item.write_data;
						else ier_q <= item.write_data;
					end
					u16550rf_pkg::OFF_LCR: lcr_q <= item.write_data;
					u16550rf_pkg::OFF_MCR: mcr_q <= item.write_data;
					u16550rf_pkg::OFF_SCR: scr_q <= item.write_data;
					default: ;
				endcase
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_rx_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.op == u16550rf_pkg::OP_RX && !rx_full_q |=> rx_full_q)
		else $error("receive into empty holding register did not fill it");

	a_rbr_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fire && rbr_read |=> !rx_full_q)
		else $error("receive buffer read did not empty holding register");

	a_tx_decode: assert property (@(posedge clk) disable iff (!arst_n)
		result.tx_valid |-> item.op == u16550rf_pkg::OP_WRITE
			&& item.offset == u16550rf_pkg::OFF_RBR_THR && !dlab)
		else $error("transmit word outside a transmit register write");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		result.rx_dropped |-> rx_full_q && result.read_data == '0 && !result.tx_valid)
		else $error("drop flagged with empty holding register");
`endif

endmodule

FILE: rtl/u16550rf_out.sv
// result register toward the master side
module u16550rf_out (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  u16550rf_pkg::result_t result,
	output logic                  ready,
	output u16550rf_pkg::result_t result_s2,
	output logic                  valid_s2,
	input  logic                  take
);

	assign ready = !valid_s2 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && ready) begin
			result_s2 <= result;
		end
	end

endmodule

FILE: rtl/uart_16550_register_file.sv
// 16550-style uart register file: takes bus reads, bus writes and received
// bytes as one stream of words and gives one result word for each. A word is
// held in an input register, decoded against the register state in one pass
// and captured in a result register, so a new word is taken every cycle unless
// m_tready stalls a full result register. The word moves from the input register
// to the result register; s_tready follows m_tready when both are full.
module uart_16550_register_file (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [u16550rf_pkg::S_TDATA_W-1:0]   s_tdata,  // reg_offset, write_data, rx_data
	input  logic [u16550rf_pkg::S_TUSER_W-1:0]   s_tuser,  // operation
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [u16550rf_pkg::M_TDATA_W-1:0]   m_tdata,  // read_data, tx_byte
	output logic [u16550rf_pkg::M_TUSER_W-1:0]   m_tuser   // tx_valid, rx_dropped
);

	u16550rf_pkg::item_t   item_s1;
	logic                  valid_s1;
	logic                  out_ready;
	logic                  fire;
	u16550rf_pkg::result_t result;
	u16550rf_pkg::result_t result_s2;
	logic                  valid_s2;

	assign fire     = valid_s1 && out_ready;
	assign s_tready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.op         <= u16550rf_pkg::op_t'(s_tuser);
			item_s1.offset     <= s_tdata[2:0];
			item_s1.write_data <= s_tdata[10:3];
			item_s1.rx_data    <= s_tdata[18:11];
		end
	end

	u16550rf_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.result (result)
	);

	u16550rf_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (valid_s1),
		.result    (result),
		.ready     (out_ready),
		.result_s2 (result_s2),
		.valid_s2  (valid_s2),
		.take      (m_tready)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {result_s2.tx_byte, result_s2.read_data};
	assign m_tuser  = {result_s2.rx_dropped, result_s2.tx_valid};

endmodule

FILE: test/tb_uart_16550_register_file.sv
// self-checking testbench for the 16550-style uart register file stream block
`timescale 1ns / 100ps

module tb_uart_16550_register_file;

	localparam logic [u16550rf_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 10;
	localparam int RANDOM_WORDS = 300;

	class uart_regs_scoreboard;
		logic [u16550rf_pkg::BYTE_W-1:0] ier, lcr, mcr, scr, dll, dlm, rx_hold;
		bit rx_full;
		u16550rf_pkg::result_t expected_q[$];
		int errors;

		function new();
			ier = '0;
			lcr = '0;
			mcr = '0;
			scr = '0;
			dll = u16550rf_pkg::DLL_RESET;
			dlm = '0;
			rx_hold = '0;
			rx_full = 0;
			errors = 0;
		endfunction

		function void note_word(logic [u16550rf_pkg::OP_W-1:0] op,
				logic [u16550rf_pkg::OFF_W-1:0] off,
				logic [u16550rf_pkg::BYTE_W-1:0] wd, logic [u16550rf_pkg::BYTE_W-1:0] rd);
			u16550rf_pkg::result_t res;
			res = '0;
			case (op)
				u16550rf_pkg::OP_READ: begin
					case (off)
						u16550rf_pkg::OFF_RBR_THR: begin
							if (lcr[u16550rf_pkg::DLAB_BIT]) begin
								res.read_data = dll;
							end else if (rx_full) begin
								res.read_data = rx_hold;
								rx_full = 0;
							end
						end
						u16550rf_pkg::OFF_IER:
							res.read_data = lcr[u16550rf_pkg::DLAB_BIT] ? dlm : ier;
						u16550rf_pkg::OFF_IIR_FCR: res.read_data = u16550rf_pkg::IIR_NONE;
						u16550rf_pkg::OFF_LCR:     res.read_data = lcr;
						u16550rf_pkg::OFF_MCR:     res.read_data = mcr;
						u16550rf_pkg::OFF_LSR:     res.read_data = u16550rf_pkg::LSR_THRE
							| u16550rf_pkg::LSR_TEMT | (rx_full ? u16550rf_pkg::LSR_DR : '0);
						u16550rf_pkg::OFF_MSR:     res.read_data = '0;
						default:                   res.read_data = scr;
					endcase
				end
				u16550rf_pkg::OP_WRITE: begin
					case (off)
						u16550rf_pkg::OFF_RBR_THR: begin
							if (lcr[u16550rf_pkg::DLAB_BIT]) begin
								dll = wd;
							end else begin
								res.tx_valid = 1'b1;
								res.tx_byte = wd;
							end
						end
						u16550rf_pkg::OFF_IER: begin
							if (lcr[u16550rf_pkg::DLAB_BIT]) dlm = wd;
							else ier = wd;
						end
						u16550rf_pkg::OFF_LCR: lcr = wd;
						u16550rf_pkg::OFF_MCR: mcr = wd;
						u16550rf_pkg::OFF_SCR: scr = wd;
						default: ;
					endcase
				end
				u16550rf_pkg::OP_RX: begin
					if (rx_full) begin
						res.rx_dropped = 1'b1;
					end else begin
						rx_hold = rd;
						rx_full = 1;
					end
				end
				default: ;
			endcase
			expected_q.push_back(res);
		endfunction

		function void check_word(logic [u16550rf_pkg::M_TDATA_W-1:0] tdata,
				logic [u16550rf_pkg::M_TUSER_W-1:0] tuser);
			u16550rf_pkg::result_t exp_res;
			if (expected_q.size() == 0) begin
				$error("result word with nothing expected: tdata=%h tuser=%b", tdata, tuser);
				errors++;
				return;
			end
			exp_res = expected_q.pop_front();
			if (tdata[7:0] !== exp_res.read_data) begin
				$error("read_data expected %h actual %h", exp_res.read_data, tdata[7:0]);
				errors++;
			end
			if (tdata[15:8] !== exp_res.tx_byte) begin
				$error("tx_byte expected %h actual %h", exp_res.tx_byte, tdata[15:8]);
				errors++;
			end
			if (tuser[0] !== exp_res.tx_valid) begin
				$error("tx_valid expected %b actual %b", exp_res.tx_valid, tuser[0]);
				errors++;
			end
			if (tuser[1] !== exp_res.rx_dropped) begin
				$error("rx_dropped expected %b actual %b", exp_res.rx_dropped, tuser[1]);
				errors++;
			end
		endfunction
	endclass

	logic                               clk;
	logic                               arst_n;
	logic                               s_tvalid;
	logic                               s_tready;
	logic [u16550rf_pkg::S_TDATA_W-1:0] s_tdata;  // reg_offset, write_data, rx_data
	logic [u16550rf_pkg::S_TUSER_W-1:0] s_tuser;  // operation
	logic                               m_tvalid;
	logic                               m_tready;
	logic [u16550rf_pkg::M_TDATA_W-1:0] m_tdata;  // read_data, tx_byte
	logic [u16550rf_pkg::M_TUSER_W-1:0] m_tuser;  // tx_valid, rx_dropped

	uart_regs_scoreboard sb;
	int idle_pct;
	int stall_pct;
	int cycles;

	uart_16550_register_file i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_word(s_tuser, s_tdata[2:0], s_tdata[10:3], s_tdata[18:11]);
			if (m_tvalid && m_tready)
				sb.check_word(m_tdata, m_tuser);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_word(logic [u16550rf_pkg::OP_W-1:0] op,
			logic [u16550rf_pkg::OFF_W-1:0] off,
			logic [u16550rf_pkg::BYTE_W-1:0] wd, logic [u16550rf_pkg::BYTE_W-1:0] rd);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {5'd0, rd, wd, off};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_random();
		int pick;
		logic [31:0] rnd_off;
		logic [31:0] rnd_wd;
		logic [31:0] rnd_rd;
		logic [u16550rf_pkg::OP_W-1:0] op;
		pick = $urandom_range(99);
		if (pick < 35) op = u16550rf_pkg::OP_READ;
		else if (pick < 70) op = u16550rf_pkg::OP_WRITE;
		else if (pick < 92) op = u16550rf_pkg::OP_RX;
		else op = OP_UNUSED;
		rnd_off = $urandom_range(7);
		rnd_wd = $urandom_range(255);
		rnd_rd = $urandom_range(255);
		send_word(op, rnd_off[u16550rf_pkg::OFF_W-1:0], rnd_wd[u16550rf_pkg::BYTE_W-1:0],
			rnd_rd[u16550rf_pkg::BYTE_W-1:0]);
	endtask

	task automatic send_directed();
		logic [31:0] off;
		for (off = 0; off < 8; off++)
			send_word(u16550rf_pkg::OP_READ, off[u16550rf_pkg::OFF_W-1:0], 8'h00, 8'h00);
		send_word(u16550rf_pkg::OP_RX, u16550rf_pkg::OFF_RBR_THR, 8'h00, 8'hff);
		send_word(u16550rf_pkg::OP_RX, u16550rf_pkg::OFF_RBR_THR, 8'h00, 8'h00);
		send_word(u16550rf_pkg::OP_READ, u16550rf_pkg::OFF_LSR, 8'h00, 8'h00);
		send_word(u16550rf_pkg::OP_READ, u16550rf_pkg::OFF_RBR_THR, 8'h00, 8'h00);
		send_word(u16550rf_pkg::OP_READ, u16550rf_pkg::OFF_LSR, 8'h00, 8'h00);
		send_word(u16550rf_pkg::OP_WRITE, u16550rf_pkg::OFF_RBR_THR, 8'h00, 8'h00);
		send_word(u16550rf_pkg::OP_WRITE, u16550rf_pkg::OFF_RBR_THR, 8'hff, 8'h00);
		send_word(u16550rf_pkg::OP_WRITE, u16550rf_pkg::OFF_IER, 8'hff, 8'h00);
		send_word(u16550rf_pkg::OP_WRITE, u16550rf_pkg::OFF_IIR_FCR, 8'hff, 8'h00);
		send_word(u16550rf_pkg::OP_WRITE, u16550rf_pkg::OFF_LSR, 8'hff, 8'h00);
		send_word(u16550rf_pkg::OP_WRITE, u16550rf_pkg::OFF_MSR, 8'hff, 8'h00);
		send_word(u16550rf_pkg::OP_WRITE, u16550rf_pkg::OFF_SCR, 8'ha5, 8'h00);
		send_word(u16550rf_pkg::OP_WRITE, u16550rf_pkg::OFF_LCR, 8'h80, 8'h00);
		send_word(u16550rf_pkg::OP_READ, u16550rf_pkg::OFF_RBR_THR, 8'h00, 8'h00);
		send_word(u16550rf_pkg::OP_WRITE, u16550rf_pkg::OFF_RBR_THR, 8'hff, 8'h00);
		send_word(u16550rf_pkg::OP_WRITE, u16550rf_pkg::OFF_IER, 8'hff, 8'h00);
		send_word(u16550rf_pkg::OP_READ, u16550rf_pkg::OFF_IER, 8'h00, 8'h00);
		send_word(u16550rf_pkg::OP_WRITE, u16550rf_pkg::OFF_LCR, 8'h03, 8'h00);
		send_word(OP_UNUSED, u16550rf_pkg::OFF_SCR, 8'hff, 8'hff);
	endtask

	initial begin
		int phase;
		int n;
		int idle_set [4];
		int stall_set [4];
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		sb = new();
		idle_set = '{0, 67, 0, 35};
		stall_set = '{0, 0, 67, 35};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_directed();
		for (phase = 0; phase < 4; phase++) begin
			idle_pct = idle_set[phase];
			stall_pct = stall_set[phase];
			for (n = 0; n < RANDOM_WORDS; n++) send_random();
		end
		s_tvalid <= 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
